@@ rtl/fsbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsbd_pkg
// Shared constants, types and arithmetic helpers for the binary error
// diffusion dither.
// ----------------------------------------------------------------------------
package fsbd_pkg;

    // line store and image geometry
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int ERR_W      = 10;
    localparam int Q_W        = PIX_W + 1;
    localparam int MULT_W     = 3;
    localparam int DIV_SHIFT  = 4;

    localparam logic [PIX_W-1:0]   PIX_MAX      = '1;
    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    // sixteenths of the error sent to each neighbour
    localparam logic [MULT_W-1:0] SHARE_RIGHT       = 3'd7;
    localparam logic [MULT_W-1:0] SHARE_BELOW_LEFT  = 3'd3;
    localparam logic [MULT_W-1:0] SHARE_BELOW       = 3'd5;
    localparam logic [MULT_W-1:0] SHARE_BELOW_RIGHT = 3'd1;

    typedef logic signed [ERR_W-1:0] t_err;

    // clamp a one-bit-wider error word to the stored range
    function automatic t_err sat_err(input logic signed [ERR_W:0] v);
        t_err res;
        if (v[ERR_W] != v[ERR_W-1]) begin
            res = {v[ERR_W], {(ERR_W-1){~v[ERR_W]}}};
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

    // q * mult / 16, rounded toward zero
    function automatic t_err share(input logic signed [Q_W-1:0] q,
                                   input logic [MULT_W-1:0] mult);
        logic signed [Q_W+DIV_SHIFT-1:0] prod;
        logic signed [Q_W+DIV_SHIFT-1:0] adj;
        logic signed [Q_W+DIV_SHIFT-1:0] quo;
        prod = q * signed'({1'b0, mult});
        adj  = prod[Q_W+DIV_SHIFT-1]
             ? prod + signed'((Q_W+DIV_SHIFT)'((1 << DIV_SHIFT) - 1))
             : prod;
        quo  = adj >>> DIV_SHIFT;
        return ERR_W'(quo);
    endfunction

endpackage
`default_nettype wire

@@ rtl/fsbd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fsbd_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module fsbd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/floyd_steinberg_binary_dither.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// floyd_steinberg_binary_dither
// Binary error diffusion dither for a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Takes one grey pixel per clock and gives one 0-or-255 pixel per clock
// while i_ready does not stall the output. An accepted pixel waits in the
// read stage registers (the line error store is read at the accepting edge),
// and the arithmetic for it then loads the output register. Error for the
// next row lives in a 2048-entry RAM with a registered read, written one
// column behind the current pixel; the last-column share is parked in a
// register and written in the following free slot. Writes that coincide
// with a read are forwarded. Raise i_frame_start with the first pixel of
// every image. Width and height must be written through the configuration
// port only while the block is idle; the block does not enforce this. A zero
// value acts as 1 and values over the limits act as the limit.
// ----------------------------------------------------------------------------
module floyd_steinberg_binary_dither (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fsbd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [fsbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [fsbd_pkg::PIX_W-1:0]        i_pixel_in,
    input  wire logic                              i_frame_start,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic      [fsbd_pkg::PIX_W-1:0]        o_pixel_out
);

    localparam int COL_W   = fsbd_pkg::COL_W;
    localparam int ROW_W   = fsbd_pkg::ROW_W;
    localparam int IMG_W_W = fsbd_pkg::IMG_W_W;
    localparam int IMG_H_W = fsbd_pkg::IMG_H_W;
    localparam int PIX_W   = fsbd_pkg::PIX_W;
    localparam int ERR_W   = fsbd_pkg::ERR_W;
    localparam int Q_W     = fsbd_pkg::Q_W;

    // configuration
    logic [IMG_W_W-1:0] r_width;
    logic [IMG_H_W-1:0] r_height;

    // position of the next pixel
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    // pixel waiting for its line read
    logic               r_b_vld;
    logic [PIX_W-1:0]   r_b_pix;
    logic [COL_W-1:0]   r_b_col;
    logic               r_b_first_row;
    logic               r_b_last_row;
    logic               r_b_last_col;
    logic               r_b_fwd_vld;
    fsbd_pkg::t_err     r_b_fwd_dat;

    // running error along the row
    fsbd_pkg::t_err     r_right;
    fsbd_pkg::t_err     r_held;
    fsbd_pkg::t_err     r_carry;

    // last-column share waiting for the write port
    logic               r_tail_vld;
    logic [COL_W-1:0]   r_tail_addr;
    fsbd_pkg::t_err     r_tail_dat;

    // output register
    logic               r_o_vld;
    logic [PIX_W-1:0]   r_o_pix;

    logic               accept;
    logic               b_adv;

    logic [IMG_W_W-1:0] w_eff;
    logic [IMG_H_W-1:0] h_eff;
    logic [IMG_W_W-1:0] c_start;
    logic [IMG_W_W-1:0] c_cur;
    logic [IMG_W_W-1:0] c_inc;
    logic [IMG_H_W-1:0] r_start;
    logic [IMG_H_W-1:0] r_wrap;
    logic [IMG_H_W-1:0] r_cur;
    logic [IMG_H_W-1:0] r_inc;
    logic               wrap_start;
    logic               wrap_end;
    logic [COL_W-1:0]   pix_col;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;

    logic [ERR_W-1:0]   ram_q;
    logic               wr_en;
    logic [COL_W-1:0]   wr_addr;
    fsbd_pkg::t_err     wr_dat;
    logic               wr_norm;
    logic [COL_W-1:0]   wr_norm_addr;
    fsbd_pkg::t_err     wr_norm_dat;
    logic               tail_load;

    logic               col0;
    fsbd_pkg::t_err     above;
    fsbd_pkg::t_err     right_eff;
    fsbd_pkg::t_err     held_eff;
    fsbd_pkg::t_err     carry_eff;
    logic signed [ERR_W+1:0] sum;
    logic [PIX_W-1:0]   sat_pix;
    logic               out_hi;
    logic signed [Q_W-1:0] q;
    fsbd_pkg::t_err     r7;
    fsbd_pkg::t_err     bl;
    fsbd_pkg::t_err     bm;
    fsbd_pkg::t_err     br;
    fsbd_pkg::t_err     n_right;
    fsbd_pkg::t_err     n_held;
    fsbd_pkg::t_err     n_carry;
    fsbd_pkg::t_err     tail_dat;

    assign b_adv   = r_b_vld && (!r_o_vld || i_ready);
    assign o_ready = !r_b_vld || b_adv;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_o_vld;
    assign o_pixel_out = r_o_pix;

    // position of the incoming pixel and of the one after it
    always_comb begin
        if (r_width == '0) begin
            w_eff = IMG_W_W'(1);
        end else if (r_width > IMG_W_W'(fsbd_pkg::MAX_WIDTH)) begin
            w_eff = IMG_W_W'(fsbd_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = IMG_H_W'(1);
        end else if (r_height > IMG_H_W'(fsbd_pkg::HEIGHT_LIMIT)) begin
            h_eff = IMG_H_W'(fsbd_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = r_height;
        end

        c_start    = i_frame_start ? '0 : IMG_W_W'(r_col);
        r_start    = i_frame_start ? '0 : IMG_H_W'(r_row);
        wrap_start = (c_start >= w_eff);
        c_cur      = wrap_start ? '0 : c_start;
        r_wrap     = wrap_start ? r_start + IMG_H_W'(1) : r_start;
        r_cur      = (r_wrap >= h_eff) ? '0 : r_wrap;
        pix_col    = c_cur[COL_W-1:0];

        c_inc    = c_cur + IMG_W_W'(1);
        r_inc    = r_cur + IMG_H_W'(1);
        wrap_end = (c_inc >= w_eff);
        if (wrap_end) begin
            n_col = '0;
            n_row = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            n_col = c_inc[COL_W-1:0];
            n_row = r_cur[ROW_W-1:0];
        end
    end

    // error arithmetic for the pixel leaving the read stage
    always_comb begin
        col0      = (r_b_col == '0);
        above     = r_b_first_row ? '0
                  : (r_b_fwd_vld ? r_b_fwd_dat : signed'(ram_q));
        right_eff = col0 ? '0 : r_right;
        held_eff  = col0 ? '0 : r_held;
        carry_eff = col0 ? '0 : r_carry;

        sum = signed'((ERR_W+2)'(r_b_pix)) + (ERR_W+2)'(above)
            + (ERR_W+2)'(right_eff);
        if (sum[ERR_W+1]) begin
            sat_pix = '0;
        end else if (|sum[ERR_W:PIX_W]) begin
            sat_pix = fsbd_pkg::PIX_MAX;
        end else begin
            sat_pix = sum[PIX_W-1:0];
        end
        out_hi = sat_pix[PIX_W-1];
        q = out_hi ? signed'({1'b0, sat_pix}) - signed'({1'b0, fsbd_pkg::PIX_MAX})
                   : signed'({1'b0, sat_pix});

        r7 = fsbd_pkg::share(q, fsbd_pkg::SHARE_RIGHT);
        bl = fsbd_pkg::share(q, fsbd_pkg::SHARE_BELOW_LEFT);
        bm = fsbd_pkg::share(q, fsbd_pkg::SHARE_BELOW);
        br = fsbd_pkg::share(q, fsbd_pkg::SHARE_BELOW_RIGHT);

        if (!r_b_last_row) begin
            n_held  = col0 ? fsbd_pkg::sat_err((ERR_W+1)'(bl) + (ERR_W+1)'(bm))
                           : fsbd_pkg::sat_err((ERR_W+1)'(carry_eff) + (ERR_W+1)'(bm));
            n_carry = br;
            n_right = r_b_last_col ? '0 : r7;
        end else begin
            // below shares fold back into this row, only below-right survives
            n_held  = held_eff;
            n_carry = carry_eff;
            n_right = r_b_last_col ? '0 : r7 + br;
        end
        tail_dat = fsbd_pkg::sat_err((ERR_W+1)'(n_held) + (ERR_W+1)'(br));

        wr_norm      = b_adv && !r_b_last_row && (!col0 || r_b_last_col);
        wr_norm_addr = col0 ? r_b_col : r_b_col - COL_W'(1);
        wr_norm_dat  = col0 ? tail_dat
                            : fsbd_pkg::sat_err((ERR_W+1)'(held_eff) + (ERR_W+1)'(bl));
        tail_load    = b_adv && !r_b_last_row && !col0 && r_b_last_col;

        // the cycle after a last column never carries a normal write
        wr_en   = wr_norm || r_tail_vld;
        wr_addr = wr_norm ? wr_norm_addr : r_tail_addr;
        wr_dat  = wr_norm ? wr_norm_dat : r_tail_dat;
    end

    fsbd_ram #(
        .DATA_W (ERR_W),
        .DEPTH  (fsbd_pkg::MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_dat),
        .i_rd_en   (accept),
        .i_rd_addr (pix_col),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= fsbd_pkg::WIDTH_RESET;
            r_height   <= fsbd_pkg::HEIGHT_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_b_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
            r_tail_vld <= 1'b0;
            r_right    <= '0;
            r_held     <= '0;
            r_carry    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    fsbd_pkg::CFG_IMAGE_WIDTH: begin
                        r_width <= i_cfg_data[IMG_W_W-1:0];
                    end
                    fsbd_pkg::CFG_IMAGE_HEIGHT: begin
                        r_height <= i_cfg_data[IMG_H_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_b_vld <= 1'b1;
            end else if (b_adv) begin
                r_b_vld <= 1'b0;
            end

            if (b_adv) begin
                r_o_vld <= 1'b1;
                r_right <= n_right;
                r_held  <= n_held;
                r_carry <= n_carry;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end

            r_tail_vld <= tail_load;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix       <= i_pixel_in;
            r_b_col       <= pix_col;
            r_b_first_row <= (r_cur == '0);
            r_b_last_row  <= (r_cur == h_eff - IMG_H_W'(1));
            r_b_last_col  <= (c_cur == w_eff - IMG_W_W'(1));
            // a write landing on the address being read is not seen by the ram
            r_b_fwd_vld   <= wr_en && (wr_addr == pix_col);
            r_b_fwd_dat   <= wr_dat;
        end
        if (tail_load) begin
            r_tail_addr <= r_b_col;
            r_tail_dat  <= tail_dat;
        end
        if (b_adv) begin
            r_o_pix <= out_hi ? fsbd_pkg::PIX_MAX : '0;
        end
    end

endmodule
`default_nettype wire
